// ===== hw/rtl/u8u32_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u8u32_pkg
// Shared types and constants for the UTF-8 to UTF-32 decoder.
// ----------------------------------------------------------------------------
package u8u32_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CP_W    = 31;
    localparam int unsigned LEFT_W  = 3;
    localparam int unsigned CONT_W  = 6;

    localparam logic [LEFT_W-1:0] LEFT_NONE = 3'd0;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [CP_W-1:0]   cp_t;
    typedef logic [LEFT_W-1:0] left_t;

    // Decoder state carried from one byte to the next.
    typedef struct packed {
        left_t bytes_left;
        cp_t   accum;
    } dec_state_t;

    // Outcome of decoding one byte against the current state.
    typedef struct packed {
        logic       emit;
        cp_t        code_point;
        logic       bad_lead;
        dec_state_t state_next;
    } dec_result_t;

endpackage : u8u32_pkg
`default_nettype wire

// ===== hw/rtl/u8u32_decode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u8u32_decode
// One-byte UTF-8 decode step: lead byte classification and accumulation.
// ----------------------------------------------------------------------------
module u8u32_decode (
    input  wire u8u32_pkg::byte_t       in_byte,
    input  wire u8u32_pkg::dec_state_t  state,
    output u8u32_pkg::dec_result_t      result
);
    import u8u32_pkg::*;

    always_comb
    begin
        result                  = '0;
        result.state_next       = state;
        if (state.bytes_left != LEFT_NONE)
        begin
            // Following byte: take the low six bits, tagged or not.
            result.state_next.accum      = {state.accum[CP_W-CONT_W-1:0],
                                            in_byte[CONT_W-1:0]};
            result.state_next.bytes_left = state.bytes_left - 3'd1;
            if (state.bytes_left == 3'd1)
            begin
                result.emit       = 1'b1;
                result.code_point = {state.accum[CP_W-CONT_W-1:0],
                                     in_byte[CONT_W-1:0]};
            end
        end
        else if (!in_byte[7])
        begin
            result.emit       = 1'b1;
            result.code_point = {{(CP_W-BYTE_W){1'b0}}, in_byte};
        end
        else if (in_byte[6] && !in_byte[5])
        begin
            result.state_next.bytes_left = 3'd1;
            result.state_next.accum      = {{(CP_W-5){1'b0}}, in_byte[4:0]};
        end
        else if (in_byte[6] && !in_byte[4])
        begin
            result.state_next.bytes_left = 3'd2;
            result.state_next.accum      = {{(CP_W-4){1'b0}}, in_byte[3:0]};
        end
        else if (in_byte[6] && !in_byte[3])
        begin
            result.state_next.bytes_left = 3'd3;
            result.state_next.accum      = {{(CP_W-3){1'b0}}, in_byte[2:0]};
        end
        else if (in_byte[6] && !in_byte[2])
        begin
            result.state_next.bytes_left = 3'd4;
            result.state_next.accum      = {{(CP_W-2){1'b0}}, in_byte[1:0]};
        end
        else if (in_byte[6] && !in_byte[1])
        begin
            result.state_next.bytes_left = 3'd5;
            result.state_next.accum      = {{(CP_W-1){1'b0}}, in_byte[0]};
        end
        else
        begin
            // Stray continuation byte or 0xFE/0xFF: reject, stay at start.
            result.emit     = 1'b1;
            result.bad_lead = 1'b1;
        end
    end

endmodule : u8u32_decode
`default_nettype wire

// ===== hw/rtl/utf8_to_utf32_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_to_utf32_decoder
// Byte-serial UTF-8 (1 to 6 byte form) to UTF-32 decoder.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  in       sink       in_valid/in_stall  in_byte[7:0]
//  out      source     out_valid/out_stall code_point[30:0], bad_lead
//
//  One byte per cycle sustained while out_stall is low; a beat passes the
//  input register and the decode logic into the result register, which
//  then shows the result of a character's last byte.
//  Reset clears the decode state to a character start and empties both
//  registers. A stalled result holds; the input register still takes one
//  more beat while the result waits.
// ----------------------------------------------------------------------------
module utf8_to_utf32_decoder (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_stall,
    input  wire u8u32_pkg::byte_t  in_byte,
    output logic                   out_valid,
    input  wire                    out_stall,
    output u8u32_pkg::cp_t         code_point,
    output logic                   bad_lead
);
    import u8u32_pkg::*;

    logic        in_valid_reg;
    byte_t       byte_reg;
    dec_state_t  state_reg;
    logic        out_valid_reg;
    cp_t         code_point_reg;
    logic        bad_lead_reg;
    dec_result_t dec;
    logic        advance;

    u8u32_decode u_decode (
        .in_byte (byte_reg),
        .state   (state_reg),
        .result  (dec)
    );

    // The held beat may move on whenever the result register is free.
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                in_valid_reg <= in_valid;
            if (in_valid_reg && advance)
                state_reg <= dec.state_next;
            if (advance)
                out_valid_reg <= in_valid_reg && dec.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            byte_reg <= in_byte;
        if (advance && in_valid_reg && dec.emit)
        begin
            code_point_reg <= dec.code_point;
            bad_lead_reg   <= dec.bad_lead;
        end
    end

    assign out_valid  = out_valid_reg;
    assign code_point = code_point_reg;
    assign bad_lead   = bad_lead_reg;

`ifndef NO_ASSERTIONS
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_lead |-> code_point == '0)
        else $error("rejected byte with nonzero code point");

    a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> !in_stall)
        else $error("input stalled with empty input register");

    a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.bytes_left != 3'd6 && state_reg.bytes_left != 3'd7)
        else $error("following byte count out of range");

    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && advance && state_reg.bytes_left == 3'd1 |=> out_valid)
        else $error("last following byte gave no result");

    a_start_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && advance && state_reg.bytes_left == 3'd1
        |=> state_reg.bytes_left == LEFT_NONE)
        else $error("decoder not back at character start");
`endif

endmodule : utf8_to_utf32_decoder
`default_nettype wire
